// ===== rtl/radix2_fft_transform_macros.svh =====
// assertion helpers for the fft block
`ifndef RADIX2_FFT_TRANSFORM_MACROS_SVH
`define RADIX2_FFT_TRANSFORM_MACROS_SVH

`define FFT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define FFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/r2fft_pkg.sv =====
package r2fft_pkg;

    localparam int LOG2_MAX_POINTS = 6;
    localparam int MAX_POINTS = 1 << LOG2_MAX_POINTS;
    localparam int HALF_MAX = MAX_POINTS / 2;
    localparam int ADDR_W = LOG2_MAX_POINTS;
    localparam int TW_ADDR_W = LOG2_MAX_POINTS - 1;
    localparam int DATA_W = 23;
    localparam int TWIDDLE_BITS = 16;
    localparam int SAMPLE_W = 16;
    localparam int LG_W = 3;
    localparam int CFG_W = 3;
    localparam int STAGE_W = 3;
    localparam int PROD_W = DATA_W + TWIDDLE_BITS + 1;

    localparam logic [0:0] REG_LOG2_POINTS = 1'b0;
    localparam logic [0:0] REG_INVERSE_MODE = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [TWIDDLE_BITS-1:0] tw_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0]
    {
        DP_IDLE,
        DP_LOAD,
        DP_BFLY,
        DP_EMIT
    } dp_op_t;

    typedef struct packed
    {
        dp_op_t op;
        addr_t addr_a;
        addr_t addr_b;
        logic [TW_ADDR_W-1:0] tw_idx;
        logic last;
        logic [LG_W-1:0] lg;
        logic inverse;
    } dp_cmd_t;

    typedef struct packed
    {
        logic busy;
        logic frame_full;
    } ctl_status_t;

    // q1.15 twiddle values for angle 2*pi*k/64
    function automatic tw_t tw_cos(input logic [TW_ADDR_W-1:0] k);
        tw_t r;
        case (k)
            5'd0: r = 16'sd32767;  5'd1: r = 16'sd32610;  5'd2: r = 16'sd32138;
            5'd3: r = 16'sd31357;  5'd4: r = 16'sd30274;  5'd5: r = 16'sd28899;
            5'd6: r = 16'sd27246;  5'd7: r = 16'sd25330;  5'd8: r = 16'sd23170;
            5'd9: r = 16'sd20788;  5'd10: r = 16'sd18205; 5'd11: r = 16'sd15447;
            5'd12: r = 16'sd12540; 5'd13: r = 16'sd9512;  5'd14: r = 16'sd6393;
            5'd15: r = 16'sd3212;  5'd16: r = 16'sd0;     5'd17: r = -16'sd3212;
            5'd18: r = -16'sd6393; 5'd19: r = -16'sd9512; 5'd20: r = -16'sd12540;
            5'd21: r = -16'sd15447; 5'd22: r = -16'sd18205; 5'd23: r = -16'sd20788;
            5'd24: r = -16'sd23170; 5'd25: r = -16'sd25330; 5'd26: r = -16'sd27246;
            5'd27: r = -16'sd28899; 5'd28: r = -16'sd30274; 5'd29: r = -16'sd31357;
            5'd30: r = -16'sd32138; default: r = -16'sd32610;
        endcase
        return r;
    endfunction

    function automatic tw_t tw_sin(input logic [TW_ADDR_W-1:0] k);
        logic [TW_ADDR_W-1:0] m;
        m = (k > 5'd16) ? 5'(6'd32 - {1'b0, k}) : k;
        return tw_cos(5'(5'd16 - m));
    endfunction

endpackage

// ===== rtl/r2fft_ctrl.sv =====
module r2fft_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic cfg_we,
    input  logic [r2fft_pkg::CFG_W-1:0] cfg_index,
    input  logic [r2fft_pkg::CFG_W-1:0] cfg_data,
    output r2fft_pkg::dp_cmd_t cmd,
    output r2fft_pkg::ctl_status_t status
);

    typedef enum logic [2:0]
    {
        ST_LOAD,
        ST_SWAP,
        ST_BFLY,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [r2fft_pkg::LG_W-1:0] lg_cfg_reg, lg_cfg_next;
    logic inv_reg, inv_next;
    logic phase_reg, phase_next;
    logic [r2fft_pkg::ADDR_W:0] count_reg, count_next;
    logic [r2fft_pkg::STAGE_W-1:0] stage_reg, stage_next;
    logic [r2fft_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [r2fft_pkg::LG_W-1:0] lg_eff;
    logic [r2fft_pkg::ADDR_W:0] npts;
    logic [r2fft_pkg::ADDR_W-1:0] nmask, rev, half, grp, jj, bfly_a;
    logic [r2fft_pkg::ADDR_W-1:0] last_bfly;

    always_comb
    begin
        if (lg_cfg_reg == '0)
            lg_eff = r2fft_pkg::LG_W'(1);
        else if (lg_cfg_reg > r2fft_pkg::LG_W'(r2fft_pkg::LOG2_MAX_POINTS))
            lg_eff = r2fft_pkg::LG_W'(r2fft_pkg::LOG2_MAX_POINTS);
        else
            lg_eff = lg_cfg_reg;
        npts = (r2fft_pkg::ADDR_W+1)'(1) << lg_eff;
        nmask = r2fft_pkg::ADDR_W'(npts - 1'b1);
        last_bfly = r2fft_pkg::ADDR_W'((npts >> 1) - 1'b1);
        rev = '0;
        for (int b = 0; b < r2fft_pkg::ADDR_W; b++)
        begin
            if (b < int'(lg_eff))
                rev[int'(lg_eff) - 1 - b] = idx_reg[b];
        end
        half = r2fft_pkg::ADDR_W'(1) << (stage_reg - 1'b1);
        jj = idx_reg & (half - 1'b1);
        grp = (idx_reg & ~(half - 1'b1)) << 1;
        bfly_a = grp | jj;
    end

    always_comb
    begin
        state_next = state_reg;
        lg_cfg_next = lg_cfg_reg;
        inv_next = inv_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        stage_next = stage_reg;
        idx_next = idx_reg;
        cmd = '0;
        cmd.op = r2fft_pkg::DP_IDLE;
        cmd.lg = lg_eff;
        cmd.inverse = inv_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                r2fft_pkg::CFG_W'(r2fft_pkg::REG_LOG2_POINTS): lg_cfg_next = cfg_data;
                r2fft_pkg::CFG_W'(r2fft_pkg::REG_INVERSE_MODE): inv_next = cfg_data[0];
                default: ;
            endcase
        end
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    cmd.op = r2fft_pkg::DP_LOAD;
                    cmd.addr_a = count_reg[r2fft_pkg::ADDR_W-1:0];
                    if ((count_reg + 1'b1) >= npts)
                    begin
                        count_next = '0;
                        idx_next = '0;
                        state_next = ST_SWAP;
                    end
                    else
                        count_next = count_reg + 1'b1;
                end
            end
            ST_SWAP:
            begin
                // read cycle first, then the write back of the swapped pair
                cmd.addr_a = idx_reg;
                cmd.addr_b = rev;
                cmd.last = 1'b1;
                if ((idx_reg < rev) && !phase_reg)
                    phase_next = 1'b1;
                else
                begin
                    phase_next = 1'b0;
                    if (phase_reg)
                        cmd.op = r2fft_pkg::DP_BFLY;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == nmask)
                    begin
                        idx_next = '0;
                        stage_next = r2fft_pkg::STAGE_W'(1);
                        state_next = ST_BFLY;
                    end
                end
            end
            ST_BFLY:
            begin
                cmd.addr_a = bfly_a;
                cmd.addr_b = bfly_a | half;
                cmd.tw_idx = r2fft_pkg::TW_ADDR_W'(jj <<
                    (r2fft_pkg::STAGE_W'(r2fft_pkg::LOG2_MAX_POINTS) - stage_reg));
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    cmd.op = r2fft_pkg::DP_BFLY;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == last_bfly)
                    begin
                        idx_next = '0;
                        if (r2fft_pkg::LG_W'(stage_reg) == lg_eff)
                            state_next = ST_EMIT;
                        else
                            stage_next = stage_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.op = r2fft_pkg::DP_EMIT;
                cmd.addr_a = idx_reg;
                cmd.last = (idx_reg == nmask);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == nmask)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign status.busy = (state_reg != ST_LOAD);
    assign status.frame_full = (state_reg == ST_SWAP) && (idx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            lg_cfg_reg <= r2fft_pkg::LG_W'(r2fft_pkg::LOG2_MAX_POINTS);
            inv_reg <= 1'b0;
            phase_reg <= 1'b0;
            count_reg <= '0;
            stage_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lg_cfg_reg <= lg_cfg_next;
            inv_reg <= inv_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            stage_reg <= stage_next;
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== rtl/r2fft_datapath.sv =====
module r2fft_datapath
(
    input  logic clk,
    input  logic rst_n,
    input  r2fft_pkg::dp_cmd_t cmd,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im,
    output logic done,
    output logic signed [r2fft_pkg::DATA_W-1:0] bin_re,
    output logic signed [r2fft_pkg::DATA_W-1:0] bin_im,
    output logic bin_last
);

    // operands are read into registers the cycle before they are used
    r2fft_pkg::data_t mem_re [r2fft_pkg::MAX_POINTS];
    r2fft_pkg::data_t mem_im [r2fft_pkg::MAX_POINTS];

    r2fft_pkg::data_t ar_reg, ai_reg, br_reg, bi_reg, vr, vi;
    r2fft_pkg::tw_t wr, wi;
    logic signed [r2fft_pkg::PROD_W-1:0] pr, pim;
    logic swap;
    logic emit_reg, emit_last_reg, emit_inv_reg;
    logic [r2fft_pkg::LG_W-1:0] emit_lg_reg;
    logic done_reg, last_reg;
    r2fft_pkg::data_t ore_reg, oim_reg;

    always_comb
    begin
        swap = cmd.last;
        wr = r2fft_pkg::tw_cos(cmd.tw_idx);
        wi = cmd.inverse ? r2fft_pkg::tw_sin(cmd.tw_idx) : -r2fft_pkg::tw_sin(cmd.tw_idx);
        pr = r2fft_pkg::PROD_W'(br_reg * wr) - r2fft_pkg::PROD_W'(bi_reg * wi)
            + r2fft_pkg::PROD_W'(1 << (r2fft_pkg::TWIDDLE_BITS - 2));
        pim = r2fft_pkg::PROD_W'(br_reg * wi) + r2fft_pkg::PROD_W'(bi_reg * wr)
            + r2fft_pkg::PROD_W'(1 << (r2fft_pkg::TWIDDLE_BITS - 2));
        vr = r2fft_pkg::DATA_W'(pr >>> (r2fft_pkg::TWIDDLE_BITS - 1));
        vi = r2fft_pkg::DATA_W'(pim >>> (r2fft_pkg::TWIDDLE_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        ar_reg <= mem_re[cmd.addr_a];
        ai_reg <= mem_im[cmd.addr_a];
        br_reg <= mem_re[cmd.addr_b];
        bi_reg <= mem_im[cmd.addr_b];
        unique case (cmd.op)
            r2fft_pkg::DP_LOAD:
            begin
                mem_re[cmd.addr_a] <= r2fft_pkg::DATA_W'(sample_re);
                mem_im[cmd.addr_a] <= r2fft_pkg::DATA_W'(sample_im);
            end
            r2fft_pkg::DP_BFLY:
            begin
                if (swap)
                begin
                    mem_re[cmd.addr_a] <= br_reg;
                    mem_im[cmd.addr_a] <= bi_reg;
                    mem_re[cmd.addr_b] <= ar_reg;
                    mem_im[cmd.addr_b] <= ai_reg;
                end
                else
                begin
                    mem_re[cmd.addr_a] <= ar_reg + vr;
                    mem_im[cmd.addr_a] <= ai_reg + vi;
                    mem_re[cmd.addr_b] <= ar_reg - vr;
                    mem_im[cmd.addr_b] <= ai_reg - vi;
                end
            end
            default: ;
        endcase
        ore_reg <= emit_inv_reg ? (ar_reg >>> emit_lg_reg) : ar_reg;
        oim_reg <= emit_inv_reg ? (ai_reg >>> emit_lg_reg) : ai_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
            emit_last_reg <= 1'b0;
            emit_inv_reg <= 1'b0;
            emit_lg_reg <= '0;
            done_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            emit_reg <= (cmd.op == r2fft_pkg::DP_EMIT);
            emit_last_reg <= (cmd.op == r2fft_pkg::DP_EMIT) && cmd.last;
            emit_inv_reg <= cmd.inverse;
            emit_lg_reg <= cmd.lg;
            done_reg <= emit_reg;
            last_reg <= emit_last_reg;
        end
    end

    assign done = done_reg;
    assign bin_re = ore_reg;
    assign bin_im = oim_reg;
    assign bin_last = last_reg;

endmodule

// ===== rtl/radix2_fft_transform.sv =====
// Radix-2 FFT over 2 to 64 complex points. One sample is taken per start
// beat while busy is low. On the sample that fills the frame the block
// goes busy: a bit-reversal sweep over all N addresses with an extra read
// step for each pair that is swapped (28 pairs for 64 points), then
// (N/2)*log2(N) butterflies, each an operand read and then a write back,
// then the N bins are emitted in index order. Each bin passes the operand
// registers and then the output registers before its done beat, so the
// last two bins follow the fall of busy; the receiver cannot stall and
// must take every beat as it comes. bin_last marks the final bin.
// Configure only while idle.
`include "radix2_fft_transform_macros.svh"

module radix2_fft_transform
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [2:0] cfg_data,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    output logic done,
    output logic signed [22:0] bin_re,
    output logic signed [22:0] bin_im,
    output logic bin_last
);

    r2fft_pkg::dp_cmd_t cmd;
    r2fft_pkg::ctl_status_t status;

    r2fft_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cfg_we(cfg_we),
        .cfg_index(r2fft_pkg::CFG_W'(cfg_index)),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .status(status)
    );

    r2fft_datapath u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sample_re(sample_re),
        .sample_im(sample_im),
        .done(done),
        .bin_re(bin_re),
        .bin_im(bin_im),
        .bin_last(bin_last)
    );

    assign busy = status.busy;

    `FFT_ASSERT_IMPL(a_last_with_done, bin_last, done)
    `FFT_ASSERT_NEXT(a_no_bin_when_loading, !busy && !done, !done)
    `FFT_ASSERT_IMPL(a_full_is_busy, status.frame_full, busy)

endmodule
